/* rtl/rpsc_pkg.sv */
// ----------------------------------------------------------------------------
// rpsc_pkg
// Shared widths, register indexes, reset values and control structures of
// the ramped position speed controller.
// ----------------------------------------------------------------------------
package rpsc_pkg;

	// Width of the encoder position and target counts.
	localparam int POS_BITS = 24;

	// Width of the slow band difference |err|*256 - deadband*mult, with sign.
	localparam int WQ_W   = ((POS_BITS + 8) > 32 ? (POS_BITS + 8) : 32) + 2;
	// Width of the truncated slow band value.
	localparam int WIDE_W = WQ_W - 8;

	localparam int SPEED_W   = 16;
	localparam int ELAPSED_W = 16;
	localparam int ACC_W     = 21;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 20;

	// Quotient bits produced by the slow band divider, one per cycle.
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_SPEED      = 3'd0,
		CFG_ACCEL_STEP     = 3'd1,
		CFG_DEADBAND       = 3'd2,
		CFG_MAX_UP_SPEED   = 3'd3,
		CFG_MAX_DOWN_SPEED = 3'd4,
		CFG_EVAL_PERIOD    = 3'd5,
		CFG_SLOW_BAND_MULT = 3'd6,
		CFG_SLOW_DIVISOR   = 3'd7
	} cfg_idx_t;

	localparam logic [14:0] RST_MIN_SPEED      = 15'd3277;
	localparam logic [14:0] RST_ACCEL_STEP     = 15'd655;
	localparam logic [15:0] RST_DEADBAND       = 16'd20;
	localparam logic [14:0] RST_MAX_UP_SPEED   = 15'd32767;
	localparam logic [14:0] RST_MAX_DOWN_SPEED = 15'd32767;
	localparam logic [19:0] RST_EVAL_PERIOD    = 20'd20000;
	localparam logic [15:0] RST_SLOW_BAND_MULT = 16'd768;
	localparam logic [15:0] RST_SLOW_DIVISOR   = 16'd512;

	// Smallest divisor that the slow band division uses (1.0 in Q8.8).
	localparam logic [15:0] DIV_FLOOR = 16'd256;

	typedef struct packed {
		logic [14:0] min_speed;
		logic [14:0] accel_step;
		logic [15:0] deadband_counts;
		logic [14:0] max_up_speed;
		logic [14:0] max_down_speed;
		logic [19:0] eval_period_us;
		logic [15:0] slow_band_mult;
		logic [15:0] slow_divisor;
	} cfg_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic mul;
		logic diff;
		logic trunc;
		logic eval;
		logic div_step;
		logic sign;
		logic commit;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic need_div;
	} sts_t;

endpackage

/* rtl/rpsc_intf.sv */
// ----------------------------------------------------------------------------
// rpsc_intf
// Valid/ready channels for the position request and the speed result.
// ----------------------------------------------------------------------------
interface rpsc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rpsc_pkg::POS_BITS-1:0]  position;
	logic signed [rpsc_pkg::POS_BITS-1:0]  target;
	logic        [rpsc_pkg::ELAPSED_W-1:0] elapsed_us;

	modport source (output valid, output position, output target, output elapsed_us,
		input ready);
	modport sink (input valid, input position, input target, input elapsed_us,
		output ready);
endinterface

interface rpsc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rpsc_pkg::SPEED_W-1:0] speed_cmd;
	logic                                evaluated;

	modport source (output valid, output speed_cmd, output evaluated, input ready);
	modport sink (input valid, input speed_cmd, input evaluated, output ready);
endinterface

/* rtl/rpsc_cfg.sv */
// ----------------------------------------------------------------------------
// rpsc_cfg
// Configuration register file with its reset values.
// ----------------------------------------------------------------------------
module rpsc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [rpsc_pkg::CFG_IDX_W-1:0] idx,
	input  logic [rpsc_pkg::CFG_DAT_W-1:0] wdata,
	output rpsc_pkg::cfg_t                 cfg
);

	rpsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_speed       <= rpsc_pkg::RST_MIN_SPEED;
			cfg_q.accel_step      <= rpsc_pkg::RST_ACCEL_STEP;
			cfg_q.deadband_counts <= rpsc_pkg::RST_DEADBAND;
			cfg_q.max_up_speed    <= rpsc_pkg::RST_MAX_UP_SPEED;
			cfg_q.max_down_speed  <= rpsc_pkg::RST_MAX_DOWN_SPEED;
			cfg_q.eval_period_us  <= rpsc_pkg::RST_EVAL_PERIOD;
			cfg_q.slow_band_mult  <= rpsc_pkg::RST_SLOW_BAND_MULT;
			cfg_q.slow_divisor    <= rpsc_pkg::RST_SLOW_DIVISOR;
		end else if (we) begin
			unique case (rpsc_pkg::cfg_idx_t'(idx))
				rpsc_pkg::CFG_MIN_SPEED:      cfg_q.min_speed       <= wdata[14:0];
				rpsc_pkg::CFG_ACCEL_STEP:     cfg_q.accel_step      <= wdata[14:0];
				rpsc_pkg::CFG_DEADBAND:       cfg_q.deadband_counts <= wdata[15:0];
				rpsc_pkg::CFG_MAX_UP_SPEED:   cfg_q.max_up_speed    <= wdata[14:0];
				rpsc_pkg::CFG_MAX_DOWN_SPEED: cfg_q.max_down_speed  <= wdata[14:0];
				rpsc_pkg::CFG_EVAL_PERIOD:    cfg_q.eval_period_us  <= wdata[19:0];
				rpsc_pkg::CFG_SLOW_BAND_MULT: cfg_q.slow_band_mult  <= wdata[15:0];
				rpsc_pkg::CFG_SLOW_DIVISOR:   cfg_q.slow_divisor    <= wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/rpsc_dp.sv */
// ----------------------------------------------------------------------------
// rpsc_dp
// Datapath: time accumulation, slow band arithmetic, speed update, the
// bit-serial slow band divider, limits and the result register.
// ----------------------------------------------------------------------------
module rpsc_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rpsc_pkg::cfg_t                        cfg,
	input  rpsc_pkg::cmd_t                        cmd,
	output rpsc_pkg::sts_t                        sts,
	input  logic signed [rpsc_pkg::POS_BITS-1:0]  position,
	input  logic signed [rpsc_pkg::POS_BITS-1:0]  target,
	input  logic        [rpsc_pkg::ELAPSED_W-1:0] elapsed_us,
	output logic signed [rpsc_pkg::SPEED_W-1:0]   speed_cmd,
	output logic                                  evaluated
);

	localparam int PB = rpsc_pkg::POS_BITS;
	localparam int WQ = rpsc_pkg::WQ_W;
	localparam int WW = rpsc_pkg::WIDE_W;

	// Architectural state.
	logic signed [15:0]                  speed_now_q;
	logic        [rpsc_pkg::ACC_W-1:0]   time_accum_q;

	// Working registers of the item in flight.
	logic signed [PB-1:0]                pos_q;
	logic signed [PB-1:0]                tgt_q;
	logic signed [PB:0]                  err_q;
	logic        [PB:0]                  aerr_q;
	logic        [rpsc_pkg::ACC_W-1:0]   acc_q;
	logic                                eval_q;
	logic        [31:0]                  prod_q;
	logic signed [WQ-1:0]                wq_q;
	logic signed [WW-1:0]                wide_q;
	logic signed [15:0]                  sp_q;
	logic        [15:0]                  rem_q;
	logic        [15:0]                  quo_q;
	logic                                neg_q;
	logic signed [15:0]                  speed_cmd_q;
	logic                                evaluated_q;

	logic        [rpsc_pkg::ACC_W-1:0]   acc_c;
	logic signed [PB:0]                  err_c;
	logic        [WQ-1:0]                wq_adj;
	logic        [15:0]                  abs_sp;
	logic                                in_band;
	logic                                wide_neg;
	logic                                err_pos;
	logic signed [16:0]                  ramp_sum;
	logic signed [15:0]                  ramp_sat;
	logic        [15:0]                  div_d;
	logic        [16:0]                  div_t;
	logic                                div_ge;
	logic        [16:0]                  div_diff;
	logic signed [16:0]                  forced_x;
	logic signed [15:0]                  forced;
	logic                                descend;
	logic signed [15:0]                  sp_f;
	logic signed [16:0]                  sp_x;
	logic        [16:0]                  sp_abs;
	logic signed [15:0]                  lim;

	assign acc_c = time_accum_q + rpsc_pkg::ACC_W'(elapsed_us);
	assign err_c = {target[PB-1], target} - {position[PB-1], position};

	// Truncation toward zero: a negative value is biased before the shift.
	assign wq_adj = wq_q + (wq_q[WQ-1] ? WQ'(255) : WQ'(0));

	assign abs_sp   = speed_now_q[15] ? 16'(-speed_now_q) : 16'(speed_now_q);
	assign in_band  = (PB+17)'(aerr_q) <= (PB+17)'(cfg.deadband_counts);
	assign wide_neg = wide_q[WW-1];
	assign err_pos  = !err_q[PB] && (err_q != '0);

	assign ramp_sum = {speed_now_q[15], speed_now_q}
		+ (err_pos ? $signed({2'b00, cfg.accel_step}) : -$signed({2'b00, cfg.accel_step}));
	always_comb begin
		if (ramp_sum > 17'sd32767)
			ramp_sat = 16'sh7fff;
		else if (ramp_sum < -17'sd32768)
			ramp_sat = 16'sh8000;
		else
			ramp_sat = ramp_sum[15:0];
	end

	assign sts.need_div = eval_q && !in_band && wide_neg;

	// Restoring division step; the remainder always stays below the divisor.
	assign div_d    = (cfg.slow_divisor < rpsc_pkg::DIV_FLOOR) ? rpsc_pkg::DIV_FLOOR
		: cfg.slow_divisor;
	assign div_t    = {rem_q, quo_q[15]};
	assign div_ge   = div_t >= {1'b0, div_d};
	assign div_diff = div_t - {1'b0, div_d};

	// Forced descent towards a zero target, and the output limits.
	assign forced_x = -$signed({1'b0, cfg.min_speed, 1'b0});
	assign forced   = cfg.min_speed[14] ? 16'sh8000 : forced_x[15:0];
	assign descend  = (tgt_q == '0)
		&& ($signed({{(WW-PB){pos_q[PB-1]}}, pos_q}) < wide_q);
	assign sp_f     = descend ? forced : sp_q;
	assign sp_x     = {sp_f[15], sp_f};
	assign sp_abs   = sp_x[16] ? 17'(-sp_x) : 17'(sp_x);

	always_comb begin
		if (sp_x > $signed({2'b00, cfg.max_up_speed}))
			lim = $signed({1'b0, cfg.max_up_speed});
		else if (sp_x < -$signed({2'b00, cfg.max_down_speed}))
			lim = -$signed({1'b0, cfg.max_down_speed});
		else if (sp_abs < {2'b00, cfg.min_speed})
			lim = '0;
		else
			lim = sp_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_now_q  <= '0;
			time_accum_q <= '0;
		end else if (cmd.commit) begin
			speed_now_q  <= lim;
			time_accum_q <= eval_q ? '0 : acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q  <= position;
			tgt_q  <= target;
			err_q  <= err_c;
			acc_q  <= acc_c;
			eval_q <= acc_c >= rpsc_pkg::ACC_W'(cfg.eval_period_us);
		end
		if (cmd.mul) begin
			prod_q <= cfg.deadband_counts * cfg.slow_band_mult;
			aerr_q <= err_q[PB] ? (PB+1)'(-err_q) : (PB+1)'(err_q);
		end
		if (cmd.diff)
			wq_q <= $signed({(WQ-8)'(aerr_q), 8'h00}) - $signed(WQ'(prod_q));
		if (cmd.trunc)
			wide_q <= $signed(wq_adj[WQ-1:8]);
		if (cmd.eval) begin
			if (!eval_q)
				sp_q <= speed_now_q;
			else if (in_band)
				sp_q <= '0;
			else if (wide_neg) begin
				rem_q <= {8'h00, abs_sp[15:8]};
				quo_q <= {abs_sp[7:0], 8'h00};
				neg_q <= speed_now_q[15];
			end else if (abs_sp < {1'b0, cfg.min_speed})
				sp_q <= err_pos ? $signed({1'b0, cfg.min_speed})
					: -$signed({1'b0, cfg.min_speed});
			else
				sp_q <= ramp_sat;
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[15:0] : div_t[15:0];
			quo_q <= {quo_q[14:0], div_ge};
		end
		if (cmd.sign)
			sp_q <= neg_q ? $signed(-quo_q) : $signed(quo_q);
		if (cmd.commit) begin
			speed_cmd_q <= lim;
			evaluated_q <= eval_q;
		end
	end

	assign speed_cmd = speed_cmd_q;
	assign evaluated = evaluated_q;

endmodule

/* rtl/rpsc_ctrl.sv */
// ----------------------------------------------------------------------------
// rpsc_ctrl
// Sequencer: steps one request through the datapath and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module rpsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  rpsc_pkg::sts_t sts,
	output rpsc_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_DIFF  = 8'b0000_0100,
		S_TRUNC = 8'b0000_1000,
		S_EVAL  = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_SIGN  = 8'b0100_0000,
		S_LIM   = 8'b1000_0000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	logic [rpsc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           out_valid_q;
	logic                           commit;
	logic                           last_step;

	// The result register is refilled as soon as it is empty or being taken.
	assign commit    = (state_q == S_LIM) && (!out_valid_q || out_ready);
	assign last_step = cnt_q == rpsc_pkg::DIV_CNT_W'(rpsc_pkg::DIV_STEPS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_MUL;
			S_MUL:   state_d = S_DIFF;
			S_DIFF:  state_d = S_TRUNC;
			S_TRUNC: state_d = S_EVAL;
			S_EVAL:  state_d = sts.need_div ? S_DIV : S_LIM;
			S_DIV:   if (last_step) state_d = S_SIGN;
			S_SIGN:  state_d = S_LIM;
			S_LIM:   if (commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EVAL)
				cnt_q <= '0;
			else if (state_q == S_DIV)
				cnt_q <= cnt_q + 1'b1;
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = out_valid_q;

	assign cmd.load     = (state_q == S_IDLE) && in_valid;
	assign cmd.mul      = state_q == S_MUL;
	assign cmd.diff     = state_q == S_DIFF;
	assign cmd.trunc    = state_q == S_TRUNC;
	assign cmd.eval     = state_q == S_EVAL;
	assign cmd.div_step = state_q == S_DIV;
	assign cmd.sign     = state_q == S_SIGN;
	assign cmd.commit   = commit;

endmodule

/* rtl/ramped_position_speed_controller.sv */
// ----------------------------------------------------------------------------
// ramped_position_speed_controller
// The request passes the multiply, difference, truncate, evaluate and limit
// states; the slow band division adds the divide states, one quotient bit per
// cycle in the datapath divider, and a sign state. The limit state waits while
// the output register is full and not being taken; the next request is taken
// while a finished result waits in the output register.
// Reset clears the current speed, the time accumulator and the sequencer and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module ramped_position_speed_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	rpsc_in_if.sink                        item,
	rpsc_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic [rpsc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rpsc_pkg::CFG_DAT_W-1:0] cfg_wdata
);

	rpsc_pkg::cfg_t cfg;
	rpsc_pkg::cmd_t cmd;
	rpsc_pkg::sts_t sts;

	rpsc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	rpsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rpsc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.position   (item.position),
		.target     (item.target),
		.elapsed_us (item.elapsed_us),
		.speed_cmd  (result.speed_cmd),
		.evaluated  (result.evaluated)
	);

endmodule

/* sim/ramped_position_speed_controller_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_position_speed_controller_test
// Drives position requests and configuration writes into the controller,
// predicts every speed command in a scoreboard of its own and compares the
// results field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module ramped_position_speed_controller_test;
	import rpsc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam longint POS_MAX = (64'sd1 <<< (POS_BITS - 1)) - 1;
	localparam longint POS_MIN = -(64'sd1 <<< (POS_BITS - 1));

	typedef struct {
		logic signed [SPEED_W-1:0] speed;
		logic                      evaluated;
	} speed_expect_t;

	typedef bit [CFG_DAT_W-1:0] reg_set_t [8];

	// Holds the controller's registers and state and the queue of predicted commands.
	class speed_cmd_board;
		bit [14:0] min_speed, accel_step, max_up_speed, max_down_speed;
		bit [15:0] deadband_counts, slow_band_mult, slow_divisor;
		bit [19:0] eval_period_us;
		bit signed [SPEED_W-1:0] speed_now;
		bit [ACC_W-1:0] time_accum;
		speed_expect_t speed_expected [$];
		int errors;

		function new();
			min_speed       = RST_MIN_SPEED;
			accel_step      = RST_ACCEL_STEP;
			deadband_counts = RST_DEADBAND;
			max_up_speed    = RST_MAX_UP_SPEED;
			max_down_speed  = RST_MAX_DOWN_SPEED;
			eval_period_us  = RST_EVAL_PERIOD;
			slow_band_mult  = RST_SLOW_BAND_MULT;
			slow_divisor    = RST_SLOW_DIVISOR;
			speed_now       = '0;
			time_accum      = '0;
			errors          = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, bit [CFG_DAT_W-1:0] value);
			case (idx)
				CFG_MIN_SPEED:      min_speed = value[14:0];
				CFG_ACCEL_STEP:     accel_step = value[14:0];
				CFG_DEADBAND:       deadband_counts = value[15:0];
				CFG_MAX_UP_SPEED:   max_up_speed = value[14:0];
				CFG_MAX_DOWN_SPEED: max_down_speed = value[14:0];
				CFG_EVAL_PERIOD:    eval_period_us = value[19:0];
				CFG_SLOW_BAND_MULT: slow_band_mult = value[15:0];
				CFG_SLOW_DIVISOR:   slow_divisor = value[15:0];
				default: ;
			endcase
		endfunction

		function longint clip16(longint x);
			if (x > 32767) return 32767;
			if (x < -32768) return -32768;
			return x;
		endfunction

		function int pending();
			return speed_expected.size();
		endfunction

		function void predict_speed(logic signed [POS_BITS-1:0] position,
				logic signed [POS_BITS-1:0] target, logic [ELAPSED_W-1:0] elapsed);
			longint pos, tgt, err, aerr, wq, wide, sp, mag, dv, db, mult, ms;
			bit [ACC_W-1:0] acc_sum;
			speed_expect_t want;
			pos = position;
			tgt = target;
			db = deadband_counts;
			mult = slow_band_mult;
			ms = min_speed;
			err = tgt - pos;
			aerr = (err < 0) ? -err : err;
			wq = aerr * 256 - db * mult;
			wide = wq / 256;
			sp = speed_now;
			acc_sum = time_accum + elapsed;
			want.evaluated = 1'b0;
			if (acc_sum >= eval_period_us) begin
				time_accum = '0;
				want.evaluated = 1'b1;
				if (aerr > db) begin
					mag = (sp < 0) ? -sp : sp;
					if (wide < 0) begin
						// Inside the slow band the command is scaled down by the divisor.
						dv = (slow_divisor < DIV_FLOOR) ? 256 : longint'(slow_divisor);
						mag = mag * 256 / dv;
						sp = (sp < 0) ? -mag : mag;
					end else if (mag < ms) begin
						sp = (err > 0) ? ms : -ms;
					end else begin
						sp = clip16(sp + ((err > 0) ? longint'(accel_step) : -longint'(accel_step)));
					end
				end else begin
					sp = 0;
				end
			end else begin
				time_accum = acc_sum;
			end
			if (tgt == 0 && pos < wide)
				sp = clip16(-2 * ms);
			if (sp > longint'(max_up_speed))
				sp = max_up_speed;
			else if (sp < -longint'(max_down_speed))
				sp = -longint'(max_down_speed);
			else if (((sp < 0) ? -sp : sp) < ms)
				sp = 0;
			speed_now = sp[SPEED_W-1:0];
			want.speed = speed_now;
			speed_expected.push_back(want);
		endfunction

		function void check_speed(logic signed [SPEED_W-1:0] got_speed, logic got_eval);
			speed_expect_t want;
			if (speed_expected.size() == 0) begin
				$error("speed result with none outstanding: speed_cmd %0d", got_speed);
				errors++;
				return;
			end
			want = speed_expected.pop_front();
			if (got_speed !== want.speed) begin
				$error("speed_cmd: expected %0d, got %0d", want.speed, got_speed);
				errors++;
			end
			if (got_eval !== want.evaluated) begin
				$error("evaluated: expected %0d, got %0d", want.evaluated, got_eval);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DAT_W-1:0] cfg_wdata;
	bit                   no_idle;
	int                   stall_cycles;

	rpsc_in_if  item_if ();
	rpsc_out_if result_if ();

	speed_cmd_board board = new();

	ramped_position_speed_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.result   (result_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Both handshakes are observed here; the watchdog ends the run if neither moves.
	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles = stall_cycles + 1;
			if (item_if.valid && item_if.ready) begin
				board.predict_speed(item_if.position, item_if.target, item_if.elapsed_us);
				stall_cycles = 0;
			end
			if (result_if.valid && result_if.ready) begin
				board.check_speed(result_if.speed_cmd, result_if.evaluated);
				stall_cycles = 0;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = idle_len();
			if (gap > 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	end

	task automatic send_request(longint pos, longint tgt, int unsigned elapsed);
		int gap;
		item_if.valid      <= 1'b1;
		item_if.position   <= pos[POS_BITS-1:0];
		item_if.target     <= tgt[POS_BITS-1:0];
		item_if.elapsed_us <= elapsed[ELAPSED_W-1:0];
		do
			@(posedge clk);
		while (!item_if.ready);
		gap = idle_len();
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The request channel is held idle until every predicted command has come back.
	task automatic wait_drained();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(reg_set_t values);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= cfg_idx_t'(i);
			cfg_wdata <= values[i];
			@(posedge clk);
			board.set_reg(cfg_idx_t'(i), values[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic pick_regs(output reg_set_t values);
		int r;
		r = $urandom_range(9);
		values[CFG_MIN_SPEED] = 20'((r == 0) ? 0 : (r == 1) ? 32767 : $urandom_range(6000));
		r = $urandom_range(9);
		values[CFG_ACCEL_STEP] = 20'((r == 0) ? 0 : (r == 1) ? 32767
			: $urandom_range(4000, 1));
		r = $urandom_range(19);
		values[CFG_DEADBAND] = 20'((r < 2) ? 0 : (r == 2) ? 65535 : $urandom_range(300));
		r = $urandom_range(19);
		values[CFG_SLOW_BAND_MULT] = 20'((r < 2) ? 0 : (r == 2) ? 65535
			: $urandom_range(2048));
		for (int i = CFG_MAX_UP_SPEED; i <= CFG_MAX_DOWN_SPEED; i++)
			values[i] = 20'(($urandom_range(9) < 7) ? $urandom_range(32767, 10000)
				: $urandom_range(32767));
		r = $urandom_range(9);
		values[CFG_EVAL_PERIOD] = 20'((r < 2) ? 0 : (r < 4) ? 20000
			: (r < 8) ? $urandom_range(65535, 1) : (r == 8) ? 1048575
			: $urandom_range(1048575, 65536));
		r = $urandom_range(19);
		values[CFG_SLOW_DIVISOR] = 20'((r < 14) ? $urandom_range(4096, 256) : (r == 14) ? 256
			: (r < 18) ? $urandom_range(65535, 4097) : $urandom_range(255));
	endtask

	// Positions are mostly placed relative to the deadband and slow band edges.
	task automatic pick_request(output longint pos, output longint tgt,
			output int unsigned elapsed);
		longint e, band;
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			pos = $signed(POS_BITS'($urandom));
			tgt = $signed(POS_BITS'($urandom));
		end else begin
			r = $urandom_range(9);
			if (r < 2)
				tgt = 0;
			else if (r < 9)
				tgt = longint'($urandom_range(200000)) - 100000;
			else
				tgt = $signed(POS_BITS'($urandom));
			band = longint'(board.deadband_counts) * board.slow_band_mult / 256 + 1;
			if (band > 4000000)
				band = 4000000;
			case ($urandom_range(3))
				0: e = $urandom_range(board.deadband_counts);
				1: e = $urandom_range(32'(band + 1), 32'(board.deadband_counts) + 1);
				2: e = band + $urandom_range(2000);
				default: e = $urandom_range(1 << 22);
			endcase
			if ($urandom_range(1))
				e = -e;
			pos = tgt - e;
			if (pos > POS_MAX || pos < POS_MIN)
				pos = tgt + e;
		end
		r = $urandom_range(9);
		if (board.eval_period_us <= 65535 && r < 6)
			elapsed = $urandom_range(65535, board.eval_period_us);
		else if (r < 8)
			elapsed = $urandom_range(65535);
		else if (r == 8)
			elapsed = 65535;
		else
			elapsed = $urandom_range(20);
	endtask

	task automatic run_random(int count);
		longint pos, tgt;
		int unsigned elapsed;
		for (int i = 0; i < count; i++) begin
			pick_request(pos, tgt, elapsed);
			send_request(pos, tgt, elapsed);
			if ($urandom_range(49) == 0)
				wait_drained();
		end
	endtask

	task automatic run_directed();
		send_request(0, 0, 0);
		send_request(0, 10000, 19999);
		send_request(0, 10000, 1);
		send_request(100, 10000, 65535);
		send_request(200, 10000, 20000);
		send_request(9950, 10000, 20000);
		send_request(0, 10000, 20000);
		send_request(9995, 10000, 20000);
		send_request(10000, -5000, 20000);
		send_request(10000, -5000, 20000);
		send_request(POS_MIN, 0, 0);
		send_request(POS_MAX, POS_MIN, 65535);
		send_request(POS_MIN, POS_MAX, 65535);
		send_request(-100, 0, 20000);
		send_request(30, 0, 20000);
		send_request(0, 0, 65535);
		send_request(-1, -1, 65535);
		send_request(POS_MAX, POS_MAX, 0);
		send_request(-20, 0, 20000);
		send_request(-21, 0, 20000);
	endtask

	initial begin
		reg_set_t values;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = '0;
		cfg_wdata          = '0;
		item_if.valid      = 1'b0;
		item_if.position   = '0;
		item_if.target     = '0;
		item_if.elapsed_us = '0;
		no_idle            = 1'b0;
		stall_cycles       = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Lower extremes: zero period, zero deadband and a divisor below one.
		wait_drained();
		values = '{20'd0, 20'd32767, 20'd0, 20'd32767, 20'd32767, 20'd0, 20'd0, 20'd0};
		program_regs(values);
		run_random(50);

		// Upper extremes: the longest period, the widest band and zero limits.
		wait_drained();
		values = '{20'd32767, 20'd0, 20'd65535, 20'd0, 20'd0, 20'd1048575, 20'd65535,
			20'd65535};
		program_regs(values);
		no_idle = 1'b1;
		run_random(50);

		for (int phase = 0; phase < 8; phase++) begin
			wait_drained();
			pick_regs(values);
			program_regs(values);
			no_idle = (phase % 3 == 0);
			run_random(55);
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
